@@ src/lbs_pkg.sv @@
`default_nettype none
package lbs_pkg;

   // Fixed-point formats
   localparam int INPUT_FRAC_BITS    = 16;
   localparam int RESULT_FRAC_BITS   = 16;
   localparam int MANTISSA_FRAC_BITS = 30;

   localparam int X_W      = 32;                      // operand width
   localparam int RES_W    = 21;                      // result width
   localparam int MANT_W   = MANTISSA_FRAC_BITS + 1;  // mantissa in [1,2)
   localparam int SQ_W     = MANTISSA_FRAC_BITS + 2;  // truncated square in [1,4)
   localparam int SHIFT_W  = $clog2(X_W);             // normalise shift amount
   localparam int IPART_W  = RES_W - RESULT_FRAC_BITS;
   localparam int CNT_W    = $clog2(RESULT_FRAC_BITS);
   localparam int NORM_STEPS = SHIFT_W;
   localparam int MUL_W    = 32;
   localparam int PROD_W   = 2 * MUL_W;
   localparam int SCALE_W  = RES_W + 32;              // |l2| times a Q0.32 constant
   localparam int CONST_FRAC = 32;

   // log_base codes
   localparam logic [1:0] BASE_LOG2  = 2'd0;
   localparam logic [1:0] BASE_LN    = 2'd1;
   localparam logic [1:0] BASE_LOG10 = 2'd2;

   // Q0.32 scale constants, rounded to nearest
   localparam logic [31:0] LN2_Q32     = 32'hB172_17F8;
   localparam logic [31:0] LOG10_2_Q32 = 32'h4D10_4D42;

   // One binary-search step of the leading-one normaliser
   typedef struct packed {
      logic [SHIFT_W-1:0] amount;  // shift applied this step
      logic [X_W-1:0]     word;
   } norm_step_type;

endpackage
`default_nettype wire

@@ src/lbs_norm.sv @@
`default_nettype none
module lbs_norm (
   input  wire logic [lbs_pkg::X_W-1:0]   word_in,
   input  wire logic [lbs_pkg::CNT_W-1:0] step,
   output lbs_pkg::norm_step_type         result
);
   import lbs_pkg::*;

   logic [SHIFT_W-1:0] span;
   logic               top_zero;

   // step 0 tests 16 bits, then 8, 4, 2, 1
   always_comb begin
      case (step)
         CNT_W'(0): span = SHIFT_W'(16);
         CNT_W'(1): span = SHIFT_W'(8);
         CNT_W'(2): span = SHIFT_W'(4);
         CNT_W'(3): span = SHIFT_W'(2);
         default:   span = SHIFT_W'(1);
      endcase
   end

   assign top_zero = ((word_in >> (X_W - int'(span))) == '0);

   always_comb begin
      result.amount = top_zero ? span : '0;
      result.word   = top_zero ? (word_in << span) : word_in;
   end

endmodule
`default_nettype wire

@@ src/lbs_mul.sv @@
`default_nettype none
module lbs_mul (
   input  wire logic [lbs_pkg::MUL_W-1:0]  op_a,
   input  wire logic [lbs_pkg::MUL_W-1:0]  op_b,
   output      logic [lbs_pkg::PROD_W-1:0] product
);
   import lbs_pkg::*;

   // shared unsigned multiplier: mantissa squaring and final base scaling
   assign product = PROD_W'(op_a) * PROD_W'(op_b);

endmodule
`default_nettype wire

@@ src/binary_log_by_squaring.sv @@
`default_nettype none
// Channel   | Ports                                   | Handshake
// ----------+-----------------------------------------+-------------------------------
// request   | req_x_value (32, Q16.16 unsigned)       | taken when start & !busy
// response  | rsp_log_result (21, Q5.16 signed),      | rsp_valid for one cycle,
//           | rsp_invalid                             | receiver cannot stall
// config    | csr_write_enable, csr_write_data (2)    | written on any enabled edge
//
// One item at a time through a single shared 32x32 multiplier. A non-zero
// operand goes through 5 leading-one search steps, 16 mantissa squarings
// (one multiply each) and base scaling: S_SCALE alone for log2, S_SCALE and
// S_FIN for ln/log10. A zero operand gives its strobe on the next cycle. busy
// is high while a non-zero item is in flight. Synchronous reset clears control
// state and sets the base to log2.
module binary_log_by_squaring (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output      logic                          busy,
   input  wire logic [lbs_pkg::X_W-1:0]       req_x_value,
   output      logic                          rsp_valid,
   output      logic signed [lbs_pkg::RES_W-1:0] rsp_log_result,
   output      logic                          rsp_invalid,
   input  wire logic                          csr_write_enable,
   input  wire logic [1:0]                    csr_write_data
);
   import lbs_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_NORM  = 3'd1;
   localparam logic [2:0] S_SQR   = 3'd2;
   localparam logic [2:0] S_SCALE = 3'd3;
   localparam logic [2:0] S_FIN   = 3'd4;

   logic [2:0]          state_ff,  state_in;
   logic [CNT_W-1:0]    cnt_ff,    cnt_in;
   logic [X_W-1:0]      x_ff,      x_in;
   logic [SHIFT_W-1:0]  shift_ff,  shift_in;
   logic [MANT_W-1:0]   m_ff,      m_in;
   logic [RESULT_FRAC_BITS-1:0] frac_ff, frac_in;
   logic [SCALE_W-1:0]  prod_ff,   prod_in;
   logic                neg_ff,    neg_in;
   logic [1:0]          base_ff;

   logic                   valid_ff,   valid_in;
   logic [RES_W-1:0]       result_ff,  result_in;
   logic                   invalid_ff, invalid_in;

   norm_step_type       norm;
   logic [MUL_W-1:0]    op_a, op_b;
   logic [PROD_W-1:0]   product;

   logic [SQ_W-1:0]     sq;
   logic                sq_big;
   logic [IPART_W-1:0]  ipart;
   logic [RES_W-1:0]    l2;
   logic [RES_W-1:0]    l2_mag;
   logic [31:0]         scale_k;
   logic [SCALE_W:0]    round_sum;
   logic [RES_W-1:0]    scaled;

   lbs_norm u_norm (
      .word_in (x_ff),
      .step    (cnt_ff),
      .result  (norm)
   );

   lbs_mul u_mul (
      .op_a    (op_a),
      .op_b    (op_b),
      .product (product)
   );

   // square of the mantissa, truncated to MANTISSA_FRAC_BITS fraction bits
   assign sq     = product[MANTISSA_FRAC_BITS +: SQ_W];
   assign sq_big = sq[SQ_W-1];

   // integer part = leading-one position minus input fraction bits;
   // for Q16.16 it spans -16..15 and l2 always fits 21 bits
   assign ipart  = IPART_W'(X_W - 1 - INPUT_FRAC_BITS) - IPART_W'(shift_ff);
   assign l2     = {ipart, frac_ff};
   assign l2_mag = l2[RES_W-1] ? (-l2) : l2;

   always_comb begin
      case (base_ff)
         BASE_LN: scale_k = LN2_Q32;
         default: scale_k = LOG10_2_Q32;
      endcase
   end

   // multiplier operand select: squaring, else scaling
   always_comb begin
      if (state_ff == S_SQR) begin
         op_a = MUL_W'(m_ff);
         op_b = MUL_W'(m_ff);
      end else begin
         op_a = MUL_W'(l2_mag);
         op_b = scale_k;
      end
   end

   // floor of the signed product: negative values round the magnitude up
   assign round_sum = (SCALE_W + 1)'(prod_ff) + (SCALE_W + 1)'({CONST_FRAC{1'b1}});
   assign scaled    = neg_ff ? (-round_sum[CONST_FRAC +: RES_W])
                             : prod_ff[CONST_FRAC +: RES_W];

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      x_in       = x_ff;
      shift_in   = shift_ff;
      m_in       = m_ff;
      frac_in    = frac_ff;
      prod_in    = prod_ff;
      neg_in     = neg_ff;
      valid_in   = 1'b0;
      result_in  = result_ff;
      invalid_in = invalid_ff;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (req_x_value == '0) begin
                  valid_in   = 1'b1;
                  result_in  = '0;
                  invalid_in = 1'b1;
               end else begin
                  x_in     = req_x_value;
                  shift_in = '0;
                  cnt_in   = '0;
                  state_in = S_NORM;
               end
            end
         end
         S_NORM: begin
            x_in     = norm.word;
            shift_in = shift_ff + norm.amount;
            cnt_in   = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(NORM_STEPS - 1)) begin
               // leading one now at the top; keep MANT_W bits, drop the rest
               m_in     = norm.word[X_W-1 -: MANT_W];
               cnt_in   = '0;
               state_in = S_SQR;
            end
         end
         S_SQR: begin
            m_in    = sq_big ? sq[SQ_W-1:1] : sq[MANT_W-1:0];
            frac_in = {frac_ff[RESULT_FRAC_BITS-2:0], sq_big};
            cnt_in  = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(RESULT_FRAC_BITS - 1)) begin
               state_in = S_SCALE;
            end
         end
         S_SCALE: begin
            if (base_ff inside {BASE_LN, BASE_LOG10}) begin
               prod_in  = product[SCALE_W-1:0];
               neg_in   = l2[RES_W-1];
               state_in = S_FIN;
            end else begin
               // log2, and the unused code, go out unscaled
               valid_in   = 1'b1;
               result_in  = l2;
               invalid_in = 1'b0;
               state_in   = S_IDLE;
            end
         end
         S_FIN: begin
            valid_in   = 1'b1;
            result_in  = scaled;
            invalid_in = 1'b0;
            state_in   = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
         base_ff  <= BASE_LOG2;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         valid_ff <= valid_in;
         if (csr_write_enable) begin
            base_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff       <= x_in;
      shift_ff   <= shift_in;
      m_ff       <= m_in;
      frac_ff    <= frac_in;
      prod_ff    <= prod_in;
      neg_ff     <= neg_in;
      result_ff  <= result_in;
      invalid_ff <= invalid_in;
   end

   assign busy           = (state_ff != S_IDLE);
   assign rsp_valid      = valid_ff;
   assign rsp_log_result = signed'(result_ff);
   assign rsp_invalid    = invalid_ff;

   // a result only ever leaves with the sequencer back at rest
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while busy");

   // invalid items carry a zero result
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_invalid) |-> (rsp_log_result == '0))
      else $error("invalid item with non-zero result");

   // the mantissa stays normalised in [1,2) through every squaring
   a_mant_norm: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SQR) |-> m_ff[MANT_W-1])
      else $error("mantissa lost its leading one");

   // an item only starts its work after an accepted start
   a_busy_start: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start))
      else $error("busy without a start");

endmodule
`default_nettype wire

@@ tb/binary_log_by_squaring_tb.sv @@
`timescale 1ns / 1ps

// Holds the shadow base register, predicts each accepted operand and matches
// strobed results in order.
class log_scoreboard;
   typedef struct {
      logic [lbs_pkg::X_W-1:0]          operand;
      logic [1:0]                       base;
      logic signed [lbs_pkg::RES_W-1:0] log_result;
      logic                             invalid;
   } log_want_type;

   // Q0.32 scale factors, rounded to nearest
   localparam logic [63:0] LN_OF_2    = 64'h0000_0000_B172_17F8;
   localparam logic [63:0] LOG10_OF_2 = 64'h0000_0000_4D10_4D42;

   logic [1:0]   log_base;
   log_want_type want_q[$];
   int           mismatches;

   function new();
      log_base   = lbs_pkg::BASE_LOG2;
      mismatches = 0;
   endfunction

   function void set_base(logic [1:0] b);
      log_base = b;
   endfunction

   function int pending();
      return want_q.size();
   endfunction

   // log2 by leading one plus 16 squarings, then optional scale (floor)
   function logic signed [lbs_pkg::RES_W-1:0] log_of(logic [31:0] x, logic [1:0] b);
      int          lead;
      logic [63:0] mant, sq, k, mag, prod;
      logic [15:0] frac;
      longint      l2, scaled;
      lead = 31;
      while (!x[lead]) lead--;
      if (lead <= 30) mant = 64'(x) << (30 - lead);
      else mant = 64'(x) >> 1;
      frac = '0;
      repeat (16) begin
         sq   = (mant * mant) >> 30;
         frac = {frac[14:0], sq >= (64'd2 << 30)};
         mant = (sq >= (64'd2 << 30)) ? (sq >> 1) : sq;
      end
      // integer part is -16..15, so l2 always fits in 21 bits
      l2 = longint'(lead - 16) * 65536 + longint'(frac);
      case (b)
         lbs_pkg::BASE_LN:    k = LN_OF_2;
         lbs_pkg::BASE_LOG10: k = LOG10_OF_2;
         default:             return l2[20:0];
      endcase
      mag  = (l2 < 0) ? 64'(-l2) : 64'(l2);
      prod = mag * k;
      if (l2 >= 0) scaled = longint'(prod >> 32);
      else scaled = -longint'((prod + 64'hFFFF_FFFF) >> 32);
      return scaled[20:0];
   endfunction

   function void note_operand(logic [lbs_pkg::X_W-1:0] x);
      log_want_type w;
      w.operand = x;
      w.base    = log_base;
      if (x == '0) begin
         w.log_result = '0;
         w.invalid    = 1'b1;
      end else begin
         w.log_result = log_of(x, log_base);
         w.invalid    = 1'b0;
      end
      want_q.push_back(w);
   endfunction

   function void check_result(logic signed [lbs_pkg::RES_W-1:0] r, logic inv);
      log_want_type w;
      if (want_q.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("%0t: unexpected result log=%0d invalid=%b", $realtime, r, inv);
         return;
      end
      w = want_q.pop_front();
      if (r !== w.log_result || inv !== w.invalid) begin
         mismatches++;
         if (mismatches <= 10)
            $display("%0t: x=%h base=%0d log exp %0d got %0d, invalid exp %b got %b",
                     $realtime, w.operand, w.base, w.log_result, r, w.invalid, inv);
      end
   endfunction
endclass

module binary_log_by_squaring_tb;
   import lbs_pkg::*;

   // Unused base code, should behave as log2
   localparam logic [1:0] BASE_SPARE = 2'd3;
   // Worst item is an ln/log10 operand plus a short random sender gap; allow plenty more
   localparam int STALL_LIMIT = 500;

   logic                    clock;
   logic                    reset;
   logic                    start;
   logic                    busy;
   logic [X_W-1:0]          req_x_value;
   logic                    rsp_valid;
   logic signed [RES_W-1:0] rsp_log_result;
   logic                    rsp_invalid;
   logic                    csr_write_enable;
   logic [1:0]              csr_write_data;

   log_scoreboard sb;
   int            stall_cycles = 0;

   binary_log_by_squaring u_top (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_x_value      (req_x_value),
      .rsp_valid        (rsp_valid),
      .rsp_log_result   (rsp_log_result),
      .rsp_invalid      (rsp_invalid),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Results are sampled on the rising edge that ends the strobe cycle
   always @(posedge clock) begin
      if (!reset && rsp_valid) sb.check_result(rsp_log_result, rsp_invalid);
   end

   // Watchdog: counts cycles in which neither an item nor a result moves
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Present one operand from a falling edge and hold it until taken. Returns on
   // the falling edge after acceptance with start still high, so back-to-back
   // items never see start dropped. An optional random gap follows.
   task automatic issue(input logic [X_W-1:0] x, input bit may_idle);
      start       = 1'b1;
      req_x_value = x;
      do @(posedge clock); while (busy);
      sb.note_operand(x);
      @(negedge clock);
      while (may_idle && $urandom_range(99) < 27) begin
         start       = 1'b0;
         req_x_value = $urandom;
         @(negedge clock);
      end
   endtask

   // Base changes only with nothing in flight
   task automatic set_base(input logic [1:0] b);
      start = 1'b0;
      while (sb.pending() != 0 || busy) @(posedge clock);
      @(negedge clock);
      csr_write_enable = 1'b1;
      csr_write_data   = b;
      @(posedge clock);
      sb.set_base(b);
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   // Mix of full-range words, chosen leading-one positions and values
   // sitting on either side of a power of two; a few zeros.
   function automatic logic [X_W-1:0] gen_operand();
      int          sel;
      logic [31:0] top;
      sel = $urandom_range(99);
      top = 32'h1 << $urandom_range(0, 31);
      if (sel < 3) return '0;
      if (sel < 43) return $urandom;
      if (sel < 85) return top | ($urandom & (top - 32'h1));
      if ($urandom_range(1)) return top + 32'($urandom_range(0, 2));
      return top - 32'($urandom_range(0, 2));
   endfunction

   // Directed operands: groups of 8, 8, 4, 4 run under log2 (reset value),
   // ln, log10 and the spare code. Covers zero, smallest and largest words,
   // exactly one, values just either side of one (negative logs), a leading
   // one at bit 30 (no shift) and at bit 31 (shift right with truncation).
   logic [X_W-1:0] dir_x [24] = '{
      32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0001_0000,
      32'h0000_8000, 32'h0000_FFFF, 32'h0001_0001, 32'hC000_0000,
      32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0001_8000,
      32'h4000_0000, 32'h7FFF_FFFF, 32'h0000_0003, 32'h0002_B7E1,
      32'h0000_0001, 32'hFFFF_FFFF, 32'h000A_0000, 32'h8000_0001,
      32'h0000_0000, 32'h0000_C000, 32'h0064_0000, 32'hFFFF_FFFF
   };
   // Base order for the first random phases, later phases draw at random
   logic [1:0] phase_base [4] = '{BASE_LN, BASE_LOG10, BASE_LOG2, BASE_SPARE};

   initial begin
      sb               = new();
      reset            = 1'b1;
      start            = 1'b0;
      req_x_value      = '0;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part; first group relies on the reset base
      for (int i = 0; i < 24; i++) begin
         if (i == 8) set_base(BASE_LN);
         if (i == 16) set_base(BASE_LOG10);
         if (i == 20) set_base(BASE_SPARE);
         issue(dir_x[i], 1'b1);
      end

      // Random part: eight phases, phase 5 runs flat out with no gaps
      for (int p = 0; p < 8; p++) begin
         set_base(p < 4 ? phase_base[p] : 2'($urandom_range(0, 3)));
         for (int i = 0; i < 212; i++) issue(gen_operand(), p != 5);
      end
      start = 1'b0;

      // Drain, then linger to catch any stray strobe
      while (sb.pending() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      if (sb.mismatches == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end
endmodule
